// ----- rtl/dfs_pkg.sv -----
package dfs_pkg;

   localparam int SURFACE_OFFSET = 17;
   localparam longint ONE_Q30 = 64'd1 << 30;
   localparam logic [13:0] INDEX_OUTSIDE_RESET = 14'd4096;
   localparam logic [13:0] INDEX_INSIDE_RESET = 14'd6144;

   typedef enum logic [0:0] {
      CSR_INDEX_OUTSIDE = 1'b0,
      CSR_INDEX_INSIDE  = 1'b1
   } csr_type;

   typedef enum logic [1:0] {
      KIND_COLOR = 2'd0,
      KIND_REFL  = 2'd1,
      KIND_TRANS = 2'd2
   } kind_type;

   typedef struct packed {
      logic               ray_alive;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic signed [47:0] hit_x;
      logic signed [47:0] hit_y;
      logic signed [47:0] hit_z;
      logic [16:0]        weight_in;
   } req_type;

   typedef struct packed {
      kind_type           result_kind;
      logic               shade_color;
      logic signed [47:0] origin_x;
      logic signed [47:0] origin_y;
      logic signed [47:0] origin_z;
      logic signed [15:0] out_dir_x;
      logic signed [15:0] out_dir_y;
      logic signed [15:0] out_dir_z;
      logic [16:0]        weight_out;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic               alive;
      logic [2:0][15:0]   d;
      logic [2:0][15:0]   n;
      logic [2:0][47:0]   hit;
      logic [16:0]        wt;
      logic [2:0][31:0]   prod;
      logic signed [33:0] dot;
      logic               swapped;
      logic [13:0]        na;
      logic [13:0]        nb;
      logic [30:0]        c;
      logic [61:0]        cc;
      logic [27:0]        na2;
      logic [27:0]        nb2;
      logic [30:0]        sin2i;
      logic [58:0]        dnum;
      logic [30:0]        dq;
      logic               ovf;
      logic               tir;
      logic [29:0]        nrem;
      logic [30:0]        nq;
      logic [61:0]        srem;
      logic [30:0]        root;
      logic [44:0]        fa;
      logic [44:0]        fb;
      logic [44:0]        fp;
      logic [44:0]        fq;
      logic [46:0]        ncl;
      logic [45:0]        nch;
      logic signed [46:0] k;
      logic [61:0]        erem_s;
      logic [61:0]        erem_p;
      logic [45:0]        eden_s;
      logic [45:0]        eden_p;
      logic [16:0]        rs;
      logic [16:0]        rp;
      logic [33:0]        rs2;
      logic [33:0]        rp2;
      logic [16:0]        rr;
      logic [16:0]        tt;
      logic [2:0][47:0]   ta;
      logic [2:0][62:0]   tb;
      logic [2:0][49:0]   dn2;
      logic [2:0][15:0]   rdir;
      logic [2:0][15:0]   tdir;
      logic [33:0]        wr2;
      logic [33:0]        wt2;
      logic [2:0][47:0]   rorg;
      logic [2:0][47:0]   torg;
      logic [16:0]        wr;
      logic [16:0]        wtr;
   } pipe_type;

   function automatic logic [15:0] sat16(input logic signed [63:0] v);
      logic [15:0] r;
      if (v > 64'sd32767) begin
         r = 16'h7FFF;
      end else if (v < -64'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic [47:0] sat48(input logic signed [63:0] v);
      logic [47:0] r;
      if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
         r = 48'h7FFF_FFFF_FFFF;
      end else if (v < -64'sh0000_8000_0000_0000) begin
         r = 48'h8000_0000_0000;
      end else begin
         r = v[47:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/dielectric_fresnel_split.sv -----
// Glass surface splitter: Snell refraction with averaged Fresnel reflectance.
// Request channel (req_valid/req_ready/req_data) takes one ray hit per request.
// Response channel (rsp_valid/rsp_ready/rsp_data) gives one or two results per
// request in order: a reflected ray and/or a transmitted ray, or a single
// colour-only result for a dead ray (black) or total internal reflection (red).
// The last flag marks the final result of each request.
// CSR channel (csr_valid/csr_ready/csr_index/csr_data) writes the two indices;
// csr_ready is always high. Write only while the block is idle.
// The datapath is a 93-stage pipeline (dot product, 31-step quotient for sin^2 T,
// 31-step square root, 17-step Fresnel ratio divide, then weights, directions
// and origins). Throughput: one request per cycle when it yields one result
// and the receiver does not stall; a request that yields two results holds
// the pipeline for its first result; the single result port sets that limit.
// Reset clears all valid bits and the response phase, and sets the indices to
// 1.0 outside and 1.5 inside. When the receiver stalls, the response register
// holds and the pipeline keeps filling until its last stage is occupied, then
// req_ready drops; nothing is lost or repeated.
module dielectric_fresnel_split
   import dfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  csr_type     csr_index,
   input  logic [13:0] csr_data
);

   localparam int ST_D0 = 7;
   localparam int ST_TIR = ST_D0 + 31;
   localparam int ST_S0 = ST_TIR + 1;
   localparam int ST_C1 = ST_S0 + 31;
   localparam int ST_E0 = ST_C1 + 2;
   localparam int ST_F1 = ST_E0 + 17;
   localparam int NST = ST_F1 + 4;

   logic [13:0]     idx_out_ff;
   logic [13:0]     idx_ins_ff;
   pipe_type        p_in [NST];
   pipe_type        p_ff [NST];
   logic [NST-1:0]  vld_ff;
   logic            adv;
   logic            load;
   logic            final_res;
   logic            phase_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_data_in;
   rsp_type         rsp_data_ff;

   function automatic pipe_type f_in(input req_type r);
      pipe_type y;
      y = '0;
      y.alive = r.ray_alive;
      y.d[0] = r.dir_x;
      y.d[1] = r.dir_y;
      y.d[2] = r.dir_z;
      y.n[0] = r.normal_x;
      y.n[1] = r.normal_y;
      y.n[2] = r.normal_z;
      y.hit[0] = r.hit_x;
      y.hit[1] = r.hit_y;
      y.hit[2] = r.hit_z;
      y.wt = r.weight_in;
      return y;
   endfunction

   function automatic pipe_type f_prod(input pipe_type x);
      pipe_type y;
      logic signed [31:0] a;
      logic signed [31:0] b;
      y = x;
      for (int j = 0; j < 3; j++) begin
         a = 32'($signed(x.d[j]));
         b = 32'($signed(x.n[j]));
         y.prod[j] = a * b;
      end
      return y;
   endfunction

   function automatic pipe_type f_dot(input pipe_type x, input logic [13:0] io,
                                      input logic [13:0] ii);
      pipe_type y;
      logic signed [33:0] dt;
      logic [33:0] ad;
      logic [13:0] a;
      logic [13:0] b;
      y = x;
      dt = 34'($signed(x.prod[0])) + 34'($signed(x.prod[1])) + 34'($signed(x.prod[2]));
      y.dot = dt;
      y.swapped = !dt[33] && (dt != 34'sd0);
      ad = dt[33] ? 34'(-dt) : 34'(dt);
      y.c = (ad > 34'(ONE_Q30)) ? 31'(ONE_Q30) : ad[30:0];
      a = y.swapped ? ii : io;
      b = y.swapped ? io : ii;
      y.na = (a == 14'd0) ? 14'd1 : a;
      y.nb = (b == 14'd0) ? 14'd1 : b;
      return y;
   endfunction

   function automatic pipe_type f_sq(input pipe_type x);
      pipe_type y;
      y = x;
      y.cc = 62'(x.c) * 62'(x.c);
      y.na2 = 28'(x.na) * 28'(x.na);
      y.nb2 = 28'(x.nb) * 28'(x.nb);
      return y;
   endfunction

   function automatic pipe_type f_sin(input pipe_type x);
      pipe_type y;
      logic [61:0] t;
      y = x;
      t = (62'd1 << 60) - x.cc;
      y.sin2i = t[60:30];
      return y;
   endfunction

   function automatic pipe_type f_num(input pipe_type x);
      pipe_type y;
      y = x;
      y.dnum = 59'(x.na2) * 59'(x.sin2i);
      y.nrem = {x.na, 16'd0};
      y.dq = '0;
      y.nq = '0;
      return y;
   endfunction

   function automatic pipe_type f_ovf(input pipe_type x);
      pipe_type y;
      y = x;
      y.ovf = x.dnum >= {x.nb2, 31'd0};
      return y;
   endfunction

   function automatic pipe_type f_div(input pipe_type x, input int i);
      pipe_type y;
      logic [58:0] tr;
      logic [44:0] tn;
      y = x;
      tr = 59'(x.nb2) << i;
      if (x.dnum >= tr) begin
         y.dnum = x.dnum - tr;
         y.dq[i] = 1'b1;
      end
      tn = 45'(x.nb) << i;
      if ({15'd0, x.nrem} >= tn) begin
         y.nrem = x.nrem - tn[29:0];
         y.nq[i] = 1'b1;
      end
      return y;
   endfunction

   function automatic pipe_type f_tir(input pipe_type x);
      pipe_type y;
      logic [30:0] dif;
      y = x;
      y.tir = x.ovf || (x.dq > 31'(ONE_Q30));
      dif = 31'(ONE_Q30) - x.dq;
      y.srem = y.tir ? 62'd0 : (62'(dif) << 30);
      y.root = '0;
      return y;
   endfunction

   function automatic pipe_type f_sqrt(input pipe_type x, input int i);
      pipe_type y;
      logic [61:0] t;
      y = x;
      t = (62'(x.root) << (i + 1)) + (62'd1 << (2 * i));
      if (x.srem >= t) begin
         y.srem = x.srem - t;
         y.root[i] = 1'b1;
      end
      return y;
   endfunction

   function automatic pipe_type f_c1(input pipe_type x);
      pipe_type y;
      y = x;
      y.fa = 45'(x.na) * 45'(x.c);
      y.fb = 45'(x.nb) * 45'(x.root);
      y.fp = 45'(x.nb) * 45'(x.c);
      y.fq = 45'(x.na) * 45'(x.root);
      y.ncl = 47'(x.nq) * 47'(x.c[15:0]);
      y.nch = 46'(x.nq) * 46'(x.c[30:16]);
      return y;
   endfunction

   function automatic pipe_type f_c2(input pipe_type x);
      pipe_type y;
      logic [62:0] s;
      y = x;
      y.eden_s = 46'(x.fa) + 46'(x.fb);
      y.eden_p = 46'(x.fp) + 46'(x.fq);
      y.erem_s = 62'((x.fa > x.fb) ? (x.fa - x.fb) : (x.fb - x.fa)) << 16;
      y.erem_p = 62'((x.fp > x.fq) ? (x.fp - x.fq) : (x.fq - x.fp)) << 16;
      y.rs = '0;
      y.rp = '0;
      s = (63'(x.nch) << 16) + 63'(x.ncl);
      y.k = $signed({1'b0, s[61:16]}) - $signed({16'd0, x.root});
      return y;
   endfunction

   function automatic pipe_type f_fres(input pipe_type x, input int i);
      pipe_type y;
      logic [61:0] t;
      y = x;
      t = 62'(x.eden_s) << i;
      if (x.erem_s >= t) begin
         y.erem_s = x.erem_s - t;
         y.rs[i] = 1'b1;
      end
      t = 62'(x.eden_p) << i;
      if (x.erem_p >= t) begin
         y.erem_p = x.erem_p - t;
         y.rp[i] = 1'b1;
      end
      return y;
   endfunction

   function automatic pipe_type f_f1(input pipe_type x);
      pipe_type y;
      logic [16:0] a;
      logic [16:0] b;
      logic signed [47:0] qa;
      logic signed [47:0] da;
      logic signed [62:0] kk;
      logic signed [62:0] nn;
      logic signed [49:0] dd;
      logic signed [49:0] n2;
      y = x;
      a = (x.eden_s == 46'd0) ? 17'd65536 : x.rs;
      b = (x.eden_p == 46'd0) ? 17'd65536 : x.rp;
      y.rs2 = 34'(a) * 34'(a);
      y.rp2 = 34'(b) * 34'(b);
      for (int j = 0; j < 3; j++) begin
         qa = $signed({17'd0, x.nq});
         da = 48'($signed(x.d[j]));
         y.ta[j] = qa * da;
         kk = 63'(x.k);
         nn = 63'($signed(x.n[j]));
         y.tb[j] = kk * nn;
         dd = 50'(x.dot);
         n2 = 50'($signed(x.n[j]));
         y.dn2[j] = dd * n2;
      end
      return y;
   endfunction

   function automatic pipe_type f_f2(input pipe_type x);
      pipe_type y;
      logic [34:0] s;
      logic signed [63:0] v;
      logic signed [63:0] tb;
      y = x;
      s = 35'(x.rs2) + 35'(x.rp2);
      y.rr = (s[34:17] > 18'd65536) ? 17'd65536 : s[33:17];
      y.tt = 17'd65536 - y.rr;
      for (int j = 0; j < 3; j++) begin
         v = (64'($signed(x.d[j])) <<< 30) - (64'($signed(x.dn2[j])) <<< 1);
         y.rdir[j] = sat16(v >>> 30);
         tb = 64'($signed(x.tb[j]));
         v = (64'($signed(x.ta[j])) <<< 14) + (x.swapped ? -tb : tb);
         y.tdir[j] = sat16(v >>> 30);
      end
      return y;
   endfunction

   function automatic pipe_type f_f3(input pipe_type x);
      pipe_type y;
      logic signed [63:0] o;
      y = x;
      y.wr2 = 34'(x.wt) * 34'(x.rr);
      y.wt2 = 34'(x.wt) * 34'(x.tt);
      for (int j = 0; j < 3; j++) begin
         o = 64'($signed(x.hit[j]))
             + ((64'(SURFACE_OFFSET) * 64'($signed(x.rdir[j]))) >>> 15);
         y.rorg[j] = sat48(o);
         o = 64'($signed(x.hit[j]))
             + ((64'(SURFACE_OFFSET) * 64'($signed(x.tdir[j]))) >>> 15);
         y.torg[j] = sat48(o);
      end
      return y;
   endfunction

   function automatic pipe_type f_f4(input pipe_type x);
      pipe_type y;
      y = x;
      y.wr = (x.wr2[33:16] > 18'd65536) ? 17'd65536 : x.wr2[32:16];
      y.wtr = (x.wt2[33:16] > 18'd65536) ? 17'd65536 : x.wt2[32:16];
      return y;
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_out_ff <= INDEX_OUTSIDE_RESET;
         idx_ins_ff <= INDEX_INSIDE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_INDEX_OUTSIDE: idx_out_ff <= csr_data;
            CSR_INDEX_INSIDE:  idx_ins_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign p_in[0] = f_in(req_data);
   assign p_in[1] = f_prod(p_ff[0]);
   assign p_in[2] = f_dot(p_ff[1], idx_out_ff, idx_ins_ff);
   assign p_in[3] = f_sq(p_ff[2]);
   assign p_in[4] = f_sin(p_ff[3]);
   assign p_in[5] = f_num(p_ff[4]);
   assign p_in[6] = f_ovf(p_ff[5]);

   for (genvar g = 0; g < 31; g++) begin : g_div
      assign p_in[ST_D0+g] = f_div(p_ff[ST_D0+g-1], 30 - g);
   end

   assign p_in[ST_TIR] = f_tir(p_ff[ST_TIR-1]);

   for (genvar g = 0; g < 31; g++) begin : g_sqrt
      assign p_in[ST_S0+g] = f_sqrt(p_ff[ST_S0+g-1], 30 - g);
   end

   assign p_in[ST_C1]   = f_c1(p_ff[ST_C1-1]);
   assign p_in[ST_C1+1] = f_c2(p_ff[ST_C1]);

   for (genvar g = 0; g < 17; g++) begin : g_fres
      assign p_in[ST_E0+g] = f_fres(p_ff[ST_E0+g-1], 16 - g);
   end

   assign p_in[ST_F1]   = f_f1(p_ff[ST_F1-1]);
   assign p_in[ST_F1+1] = f_f2(p_ff[ST_F1]);
   assign p_in[ST_F1+2] = f_f3(p_ff[ST_F1+1]);
   assign p_in[ST_F1+3] = f_f4(p_ff[ST_F1+2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < NST; s++) begin
            p_ff[s] <= p_in[s];
         end
      end
   end

   always_comb begin
      pipe_type lx;
      logic     color;
      logic     sel_r;
      lx = p_ff[NST-1];
      color = !lx.alive || lx.tir;
      sel_r = !color && !phase_ff && (lx.rr != 17'd0);
      final_res = color || !sel_r || (lx.tt == 17'd0);
      load = vld_ff[NST-1] && (!rsp_valid_ff || rsp_ready);
      adv = !vld_ff[NST-1] || (load && final_res);
      rsp_data_in = '0;
      rsp_data_in.last = 1'b1;
      if (color) begin
         rsp_data_in.result_kind = KIND_COLOR;
         rsp_data_in.shade_color = lx.alive;
      end else if (sel_r) begin
         rsp_data_in.result_kind = KIND_REFL;
         rsp_data_in.origin_x = lx.rorg[0];
         rsp_data_in.origin_y = lx.rorg[1];
         rsp_data_in.origin_z = lx.rorg[2];
         rsp_data_in.out_dir_x = lx.rdir[0];
         rsp_data_in.out_dir_y = lx.rdir[1];
         rsp_data_in.out_dir_z = lx.rdir[2];
         rsp_data_in.weight_out = lx.wr;
         rsp_data_in.last = (lx.tt == 17'd0);
      end else begin
         rsp_data_in.result_kind = KIND_TRANS;
         rsp_data_in.origin_x = lx.torg[0];
         rsp_data_in.origin_y = lx.torg[1];
         rsp_data_in.origin_z = lx.torg[2];
         rsp_data_in.out_dir_x = lx.tdir[0];
         rsp_data_in.out_dir_y = lx.tdir[1];
         rsp_data_in.out_dir_z = lx.tdir[2];
         rsp_data_in.weight_out = lx.wtr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            phase_ff <= !final_res;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// ----- rtl/dfs_checker.sv -----
module dfs_checker
   import dfs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input rsp_type     rsp_data
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_final_kinds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.result_kind == KIND_COLOR
                    || rsp_data.result_kind == KIND_TRANS) |-> rsp_data.last)
      else $error("colour or transmitted result not marked last");

   a_ray_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind != KIND_COLOR |-> !rsp_data.shade_color)
      else $error("ray result carries red shade");

   a_color_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == KIND_COLOR |->
         rsp_data.weight_out == 17'd0)
      else $error("colour result carries weight");

endmodule

bind dielectric_fresnel_split dfs_checker u_dfs_checker (.*);
